// ----- rtl/core/slfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants for the sync/type/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam int MAX_PAYLOAD       = 64;
  localparam int TICK_BITS_DEFAULT = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int LIMIT_W           = 16;

  localparam logic [LIMIT_W-1:0] WAIT_FOREVER = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WAIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_WAIT  = 2'd2;

  // input kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SYNC_TO   = 2'd1,
    ST_DATA_TO   = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  // frame tracking state (tick counter kept apart, its width is a parameter)
  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_type;
    logic [7:0] held_length;
    logic [7:0] bytes_seen;
  } frame_state_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       has_data;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/slfr_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr channel interfaces
// Valid/ready channels for input events and frame results.
// ----------------------------------------------------------------------------
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface slfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic       has_data;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic       last;

  modport source (output valid, output status, output frame_type, output frame_length,
                  output has_data, output data_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input status, input frame_type, input frame_length,
                  input has_data, input data_byte, input byte_index, input last,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/slfr_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_step
// Next-state and result logic for one byte or tick event.
// ----------------------------------------------------------------------------
module slfr_step
  import slfr_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  frame_state_t         cur,
  input  logic [TICK_BITS-1:0] ticks,
  input  logic [7:0]           sync_value,
  input  logic [LIMIT_W-1:0]   sync_wait_limit,
  input  logic [LIMIT_W-1:0]   data_wait_limit,
  input  logic                 func,
  input  logic [7:0]           rx_byte,
  output frame_state_t         nxt,
  output logic [TICK_BITS-1:0] ticks_next,
  output logic                 res_valid,
  output result_t              res
);

  localparam int CMP_W = (TICK_BITS > LIMIT_W) ? TICK_BITS : LIMIT_W;

  logic [TICK_BITS-1:0] ticks_inc;
  logic [LIMIT_W-1:0]   limit;
  logic                 expired;
  logic [8:0]           idx_plus;
  logic                 fin;

  assign ticks_inc = (func == FUNC_TICK && ticks != '1) ? ticks + 1'b1 : ticks;
  assign limit     = (cur.phase == PH_HUNT) ? sync_wait_limit : data_wait_limit;
  assign expired   = (limit != WAIT_FOREVER) && (CMP_W'(ticks_inc) >= CMP_W'(limit));
  assign idx_plus  = {1'b0, cur.bytes_seen} + 9'd1;
  assign fin       = idx_plus >= {1'b0, cur.held_length};

  always_comb begin
    nxt              = cur;
    ticks_next       = ticks_inc;
    res_valid        = 1'b0;
    res.status       = ST_OK;
    res.frame_type   = cur.held_type;
    res.frame_length = cur.held_length;
    res.has_data     = 1'b0;
    res.data_byte    = 8'd0;
    res.byte_index   = 8'd0;
    res.last         = 1'b1;

    if (expired) begin
      // a byte arriving after expiry is dropped, same error as the tick
      res_valid   = 1'b1;
      res.status  = (cur.phase == PH_HUNT) ? ST_SYNC_TO : ST_DATA_TO;
      nxt         = '{PH_HUNT, 8'd0, 8'd0, 8'd0};
      ticks_next  = '0;
    end else if (func == FUNC_BYTE) begin
      unique case (cur.phase)
        PH_HUNT: begin
          if (rx_byte == sync_value) begin
            nxt        = '{PH_TYPE, 8'd0, 8'd0, 8'd0};
            ticks_next = '0;
          end
        end
        PH_TYPE: begin
          nxt.held_type = rx_byte;
          nxt.phase     = PH_LEN;
        end
        PH_LEN: begin
          res.frame_length = rx_byte;
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            res_valid  = 1'b1;
            res.status = ST_TOO_LARGE;
            nxt        = '{PH_HUNT, 8'd0, 8'd0, 8'd0};
            ticks_next = '0;
          end else if (rx_byte == 8'd0) begin
            res_valid  = 1'b1;
            nxt        = '{PH_HUNT, 8'd0, 8'd0, 8'd0};
            ticks_next = '0;
          end else begin
            nxt.held_length = rx_byte;
            nxt.phase       = PH_DATA;
            nxt.bytes_seen  = 8'd0;
            ticks_next      = '0;
          end
        end
        PH_DATA: begin
          res_valid      = 1'b1;
          res.has_data   = 1'b1;
          res.data_byte  = rx_byte;
          res.byte_index = cur.bytes_seen;
          res.last       = fin;
          if (fin) begin
            nxt        = '{PH_HUNT, 8'd0, 8'd0, 8'd0};
            ticks_next = '0;
          end else begin
            nxt.bytes_seen = idx_plus[7:0];
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sync_length_frame_receiver_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_core
// Hunts for a sync byte, reads type and length, passes payload bytes out,
// and reports sync/data timeouts and oversize lengths.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           handshake
//  in_ch    in   func, rx_byte                                     valid/ready
//  out_ch   out  status, frame_type, frame_length, has_data,       valid/ready
//                data_byte, byte_index, last
//  cfg      in   cfg_index, cfg_data                               cfg_we only
//
// One event per cycle; its result, if any, shows on out_ch the next cycle.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
// Reset is synchronous; the block then hunts for sync.
// Tick counter is TICK_BITS wide and saturates.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_core
  import slfr_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  slfr_in_if.sink               in_ch,
  slfr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]           sync_value;
  logic [LIMIT_W-1:0]   sync_wait_limit;
  logic [LIMIT_W-1:0]   data_wait_limit;

  frame_state_t         state;
  frame_state_t         state_next;
  logic [TICK_BITS-1:0] ticks;
  logic [TICK_BITS-1:0] ticks_next;

  logic                 step_valid;
  result_t              step_res;
  logic                 out_valid;
  result_t              out_res;
  logic                 accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value      <= 8'd0;
      sync_wait_limit <= WAIT_FOREVER;
      data_wait_limit <= WAIT_FOREVER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_VALUE: sync_value      <= cfg_data[7:0];
        REG_SYNC_WAIT:  sync_wait_limit <= cfg_data[LIMIT_W-1:0];
        REG_DATA_WAIT:  data_wait_limit <= cfg_data[LIMIT_W-1:0];
        default:        ;
      endcase
    end
  end

  slfr_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .cur             (state),
    .ticks           (ticks),
    .sync_value      (sync_value),
    .sync_wait_limit (sync_wait_limit),
    .data_wait_limit (data_wait_limit),
    .func            (in_ch.func),
    .rx_byte         (in_ch.rx_byte),
    .nxt             (state_next),
    .ticks_next      (ticks_next),
    .res_valid       (step_valid),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{PH_HUNT, 8'd0, 8'd0, 8'd0};
      ticks <= '0;
    end else if (accept) begin
      state <= state_next;
      ticks <= ticks_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= step_valid;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_valid) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_res.status;
  assign out_ch.frame_type   = out_res.frame_type;
  assign out_ch.frame_length = out_res.frame_length;
  assign out_ch.has_data     = out_res.has_data;
  assign out_ch.data_byte    = out_res.data_byte;
  assign out_ch.byte_index   = out_res.byte_index;
  assign out_ch.last         = out_res.last;

`ifndef SYNTHESIS
  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_HUNT |-> state.held_type == 8'd0 && state.held_length == 8'd0
                               && state.bytes_seen == 8'd0)
    else $error("hunt phase with stale frame state");

  a_data_bounds: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_DATA |-> state.held_length != 8'd0
                               && state.bytes_seen < state.held_length)
    else $error("payload index out of range");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    accept && step_valid |=> out_valid)
    else $error("result lost");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept && !cfg_we |=> $stable(state) && $stable(ticks))
    else $error("state moved without a beat");
`endif

endmodule
`default_nettype wire

// ----- verif/sync_length_frame_receiver_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_core_tb
// Self-checking bench for the sync/type/length frame receiver. A predictor
// in the scoreboard tracks the hunt/header/payload phases and the tick
// counter. Each accepted input beat is used to predict the next result,
// and each result beat is checked field by field. The bench runs directed
// frames and timeouts, then random frame traffic under several register
// settings, with bursty input and a receiver that stalls.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_core_tb;
  import slfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LONG_HOLD   = 300;
  localparam int RAND_ITEMS  = 450;
  localparam int PHASE_ITEMS = 60;
  localparam int HOLD_PHASE  = 5;

  typedef struct packed {
    logic       func;
    logic [7:0] b;
  } rx_event_t;

  class frame_scoreboard;
    logic [7:0]                   sync_val;
    logic [LIMIT_W-1:0]           sync_limit;
    logic [LIMIT_W-1:0]           data_limit;
    phase_t                       ph;
    logic [7:0]                   cur_type;
    logic [7:0]                   cur_len;
    logic [7:0]                   seen;
    logic [TICK_BITS_DEFAULT-1:0] ticks;
    result_t                      expected_q[$];
    int                           errors;

    function new();
      sync_val   = 8'd0;
      sync_limit = WAIT_FOREVER;
      data_limit = WAIT_FOREVER;
      errors     = 0;
      back_to_hunt();
    endfunction

    function void back_to_hunt();
      ph       = PH_HUNT;
      cur_type = 8'd0;
      cur_len  = 8'd0;
      seen     = 8'd0;
      ticks    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SYNC_VALUE: sync_val   = val[7:0];
        REG_SYNC_WAIT:  sync_limit = val[LIMIT_W-1:0];
        REG_DATA_WAIT:  data_limit = val[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit limit_hit();
      logic [LIMIT_W-1:0] lim;
      lim = (ph == PH_HUNT) ? sync_limit : data_limit;
      return (lim != WAIT_FOREVER) && (ticks >= lim);
    endfunction

    function void post(status_t st, logic hd, logic [7:0] db, logic [7:0] ix, logic lst);
      result_t r;
      r.status       = st;
      r.frame_type   = cur_type;
      r.frame_length = cur_len;
      r.has_data     = hd;
      r.data_byte    = db;
      r.byte_index   = ix;
      r.last         = lst;
      expected_q.push_back(r);
    endfunction

    function void post_timeout();
      post((ph == PH_HUNT) ? ST_SYNC_TO : ST_DATA_TO, 1'b0, 8'd0, 8'd0, 1'b1);
      back_to_hunt();
    endfunction

    function void note_event(logic func, logic [7:0] b);
      logic [8:0] nxt;
      logic       fin;
      if (func == FUNC_TICK) begin
        if (ticks != '1) ticks = ticks + 1'b1;
        if (limit_hit()) post_timeout();
        return;
      end
      // a byte that lands after the limit is already used up is dropped
      if (limit_hit()) begin
        post_timeout();
        return;
      end
      case (ph)
        PH_HUNT: begin
          if (b == sync_val) begin
            back_to_hunt();
            ph = PH_TYPE;
          end
        end
        PH_TYPE: begin
          cur_type = b;
          ph       = PH_LEN;
        end
        PH_LEN: begin
          cur_len = b;
          if (b > MAX_PAYLOAD) begin
            post(ST_TOO_LARGE, 1'b0, 8'd0, 8'd0, 1'b1);
            back_to_hunt();
          end else if (b == 8'd0) begin
            post(ST_OK, 1'b0, 8'd0, 8'd0, 1'b1);
            back_to_hunt();
          end else begin
            ph    = PH_DATA;
            seen  = 8'd0;
            ticks = '0;
          end
        end
        default: begin
          nxt = {1'b0, seen} + 9'd1;
          fin = (nxt >= {1'b0, cur_len});
          post(ST_OK, 1'b1, b, seen, fin);
          if (fin) back_to_hunt();
          else seen = nxt[7:0];
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("status", 8'(want.status), 8'(got.status));
      cmp_field("frame_type", want.frame_type, got.frame_type);
      cmp_field("frame_length", want.frame_length, got.frame_length);
      cmp_field("has_data", 8'(want.has_data), 8'(got.has_data));
      cmp_field("data_byte", want.data_byte, got.data_byte);
      cmp_field("byte_index", want.byte_index, got.byte_index);
      cmp_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slfr_in_if  in_ch();
  slfr_out_if out_ch();

  frame_scoreboard sb = new();
  rx_event_t       stim_q[$];
  int              items_made;
  bit              hold_req;
  logic [7:0]      cur_sync;

  sync_length_frame_receiver_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample both channels and register writes at the rising edge
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status       = status_t'(out_ch.status);
        got.frame_type   = out_ch.frame_type;
        got.frame_length = out_ch.frame_length;
        got.has_data     = out_ch.has_data;
        got.data_byte    = out_ch.data_byte;
        got.byte_index   = out_ch.byte_index;
        got.last         = out_ch.last;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_event(in_ch.func, in_ch.rx_byte);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: random stall segments, plus one long hold on request
  initial begin
    int mode;
    int seg;
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(5, 40);
        repeat (seg) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sync_length_frame_receiver_core_tb: done, errors");
    $finish;
  end

  function automatic void add_byte(logic [7:0] b);
    stim_q.push_back('{func: FUNC_BYTE, b: b});
    items_made++;
  endfunction

  function automatic void add_tick();
    stim_q.push_back('{func: FUNC_TICK, b: 8'($urandom)});
    items_made++;
  endfunction

  function automatic void add_ticks(int n);
    repeat (n) add_tick();
  endfunction

  function automatic void maybe_tick();
    if ($urandom_range(0, 9) == 0) add_ticks($urandom_range(1, 2));
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'($urandom_range(MAX_PAYLOAD + 1, 255));
    if (r < 23) return 8'(MAX_PAYLOAD);
    if (r < 30) return 8'($urandom_range(9, 20));
    return 8'($urandom_range(1, 8));
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return WAIT_FOREVER;
    if (r < 60) return LIMIT_W'($urandom_range(2, 20));
    if (r < 75) return LIMIT_W'($urandom_range(0, 65535));
    return LIMIT_W'($urandom_range(21, 200));
  endfunction

  // one chunk of traffic: mostly whole frames, some broken ones and noise
  function automatic void gen_chunk();
    int         r;
    logic [7:0] len;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      add_byte(cur_sync);
      maybe_tick();
      add_byte(8'($urandom));
      maybe_tick();
      len = pick_length();
      add_byte(len);
      if (len <= MAX_PAYLOAD) begin
        repeat (len) begin
          maybe_tick();
          add_byte(8'($urandom));
        end
      end
    end else if (r < 80) begin
      add_byte(cur_sync);
      if ($urandom_range(0, 1)) add_byte(8'($urandom));
      add_ticks($urandom_range(1, 10));
    end else if (r < 90) begin
      // noise bytes, mostly dropped while hunting
      repeat ($urandom_range(1, 4))
        add_byte(8'($urandom));
    end else begin
      add_ticks($urandom_range(1, 8));
    end
  endfunction

  task automatic send_event(rx_event_t ev);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= ev.func;
    in_ch.rx_byte <= ev.b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender: bursts of beats with random gaps; called at a falling edge
  task automatic play_stim();
    int        burst;
    int        gap;
    rx_event_t ev;
    while (stim_q.size() > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      while (burst > 0 && stim_q.size() > 0) begin
        ev = stim_q.pop_front();
        send_event(ev);
        burst--;
      end
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid   <= 1'b0;
        in_ch.func    <= 1'($urandom_range(0, 1));
        in_ch.rx_byte <= 8'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // registers change only once every result is out and the block settled
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_phase_regs(int k);
    logic [LIMIT_W-1:0] sl;
    logic [LIMIT_W-1:0] dl;
    case (k)
      0: begin cur_sync = 8'hFF; sl = WAIT_FOREVER; dl = WAIT_FOREVER; end
      1: begin cur_sync = 8'h00; sl = '0; dl = 16'd3; end
      2: begin
        cur_sync = 8'($urandom);
        sl = LIMIT_W'($urandom_range(1000, 65534));
        dl = '0;
      end
      3: begin cur_sync = 8'($urandom); sl = 16'd12; dl = 16'd6; end
      default: begin cur_sync = 8'($urandom); sl = pick_limit(); dl = pick_limit(); end
    endcase
    write_reg(REG_SYNC_VALUE, {8'($urandom), cur_sync});
    write_reg(REG_SYNC_WAIT, sl);
    write_reg(REG_DATA_WAIT, dl);
    if (k == 3) write_reg(REG_UNUSED, 16'($urandom));
  endtask

  initial begin
    int k;
    int goal;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_BYTE;
    in_ch.rx_byte = 8'd0;
    hold_req      = 1'b0;
    items_made    = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: sync 0x00, no timeouts
    add_byte(8'hAA);
    add_tick();
    add_byte(8'h00); add_byte(8'hFF); add_byte(8'h00);                 // zero length
    add_byte(8'h00); add_byte(8'h5A); add_byte(8'h01); add_byte(8'hFF); // one byte
    add_byte(8'h00); add_byte(8'h00); add_byte(8'(MAX_PAYLOAD + 1));   // too large
    add_byte(8'h00); add_byte(8'h81); add_byte(8'h02);
    add_byte(8'h00); add_byte(8'hFF);
    play_stim();

    wait_idle();
    write_reg(REG_SYNC_VALUE, 16'hA5FF);
    write_reg(REG_SYNC_WAIT, 16'd3);
    write_reg(REG_DATA_WAIT, 16'd2);
    add_ticks(3);                                                      // sync timeout
    // counter restarts when the payload starts, then data timeout
    add_byte(8'hFF); add_byte(8'h11); add_tick(); add_byte(8'h03);
    add_tick(); add_byte(8'h7E); add_tick();
    add_byte(8'hFF); add_byte(8'h22);
    play_stim();
    wait_idle();
    // limit dropped to zero mid-header: next byte is a timeout
    write_reg(REG_DATA_WAIT, 16'd0);
    add_byte(8'h33);
    play_stim();
    wait_idle();
    write_reg(REG_SYNC_WAIT, 16'd0);
    add_byte(8'h44);
    play_stim();

    items_made = 0;
    k = 0;
    while (items_made < RAND_ITEMS) begin
      wait_idle();
      set_phase_regs(k);
      if (k == HOLD_PHASE) hold_req = 1'b1;
      goal = items_made + PHASE_ITEMS;
      while (items_made < goal) gen_chunk();
      play_stim();
      k++;
    end

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("sync_length_frame_receiver_core_tb: done, clean");
    end else begin
      $display("sync_length_frame_receiver_core_tb: done, errors");
    end
    $finish;
  end

endmodule
